// ===== rtl/core/cau_pkg.sv =====
// Package for the complex arithmetic unit: operation codes.
// No dependencies.
package cau_pkg;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;
endpackage

// ===== rtl/core/complex_arith_unit.sv =====
// Complex add/sub/mul/div in signed fixed point.
// Every operation passes through the same stages: operands, products, magnitudes,
// a chain of restoring-division cells (one quotient bit per cell), output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits
// with stall_i high.
// Reset clears only the valid bits of the stages; payload registers are not reset.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [1:0]                  operation_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic                        overflow_o,
  output logic                        divide_by_zero_o
);
  localparam int PW    = 2 * WORD_BITS;         // product width
  localparam int SW    = PW + 1;                // sum of two products
  localparam int NUM_W = PW + FRAC_BITS + 1;    // scaled numerator magnitude
  localparam int DEN_W = PW;                    // |b|^2 fits unsigned in 2W bits
  localparam int NC    = NUM_W;                 // one cell per quotient bit

  // Global enable: the pipeline advances unless a valid output is held by stall_i.
  logic adv;
  assign adv     = !stall_i || !valid_o;
  assign stall_o = !adv;

  // Stage 1: register operands.
  logic                        v1_q;
  logic [1:0]                  op1_q;
  logic signed [WORD_BITS-1:0] ar_q, ai_q, br_q, bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      op1_q <= operation_i;
      ar_q  <= a_re_i;
      ai_q  <= a_im_i;
      br_q  <= b_re_i;
      bi_q  <= b_im_i;
    end
  end

  // Stage 2: the six products (one multiplier each) and the add/sub sums, registered.
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q;
  logic                 v2_q;
  logic [1:0]           op2_q;
  logic signed [SW-1:0] as_re_q, as_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q  <= op1_q;
      p_rr_q <= PW'(ar_q * br_q);
      p_ii_q <= PW'(ai_q * bi_q);
      p_ri_q <= PW'(ar_q * bi_q);
      p_ir_q <= PW'(ai_q * br_q);
      p_bb_q <= PW'(br_q * br_q);
      p_cc_q <= PW'(bi_q * bi_q);
      if (op1_q == OP_ADD) begin
        as_re_q <= SW'(ar_q) + SW'(br_q);
        as_im_q <= SW'(ai_q) + SW'(bi_q);
      end else begin
        as_re_q <= SW'(ar_q) - SW'(br_q);
        as_im_q <= SW'(ai_q) - SW'(bi_q);
      end
    end
  end

  // Stage 3: combine products, select per operation; form sign/magnitude numerators and the divisor.
  logic signed [SW-1:0] m_re, m_im, d_re, d_im, sel_re, sel_im;
  logic [DEN_W-1:0]     den_w;
  assign m_re  = SW'(p_rr_q) - SW'(p_ii_q);
  assign m_im  = SW'(p_ri_q) + SW'(p_ir_q);
  assign d_re  = SW'(p_rr_q) + SW'(p_ii_q);
  assign d_im  = SW'(p_ir_q) - SW'(p_ri_q);
  assign den_w = DEN_W'(p_bb_q) + DEN_W'(p_cc_q);

  always_comb begin
    case (op2_q)
      OP_MUL:  begin sel_re = m_re;    sel_im = m_im;    end
      OP_DIV:  begin sel_re = d_re;    sel_im = d_im;    end
      default: begin sel_re = as_re_q; sel_im = as_im_q; end
    endcase
  end

  logic                 v3_q;
  logic [1:0]           op3_q;
  logic                 neg_re_q, neg_im_q;
  logic [SW-1:0]        mag_re_q, mag_im_q;
  logic [DEN_W-1:0]     den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op3_q    <= op2_q;
      neg_re_q <= sel_re[SW-1];
      neg_im_q <= sel_im[SW-1];
      mag_re_q <= sel_re[SW-1] ? SW'(-sel_re) : SW'(sel_re);
      mag_im_q <= sel_im[SW-1] ? SW'(-sel_im) : SW'(sel_im);
      den_q    <= den_w;
    end
  end

  // Division chain: NC cells, each settling one quotient bit of both lanes.
  // The numerator is mag << FRAC_BITS, shifted in from the top bit first.
  logic [NUM_W-1:0] rre [NC+1];
  logic [NUM_W-1:0] nre [NC+1];
  logic [NUM_W-1:0] rim [NC+1];
  logic [NUM_W-1:0] nim [NC+1];
  logic [DEN_W-1:0] den_c [NC+1];

  assign rre[0] = '0;
  assign rim[0] = '0;
  assign nre[0] = {mag_re_q, {FRAC_BITS{1'b0}}};
  assign nim[0] = {mag_im_q, {FRAC_BITS{1'b0}}};
  assign den_c[0] = den_q;

  // Side band per stage: op, signs, magnitudes (for add/sub/mul paths), divide-by-zero flag.
  typedef struct packed {
    logic [1:0]    op;
    logic          nre;
    logic          nim;
    logic [SW-1:0] mre;
    logic [SW-1:0] mim;
    logic          dbz;
  } side_t;

  side_t sb [NC+1];
  logic  vld [NC+1];
  assign vld[0] = v3_q;
  assign sb[0] = '{op: op3_q, nre: neg_re_q, nim: neg_im_q,
                   mre: mag_re_q, mim: mag_im_q, dbz: (den_q == '0)};

  for (genvar g = 0; g < NC; g++) begin : g_chain
    cau_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_cell (
      .clk_i    (clk_i),
      .valid_i  (adv),
      .den_i    (den_c[g]),
      .rem_re_i (rre[g]),
      .num_re_i (nre[g]),
      .rem_im_i (rim[g]),
      .num_im_i (nim[g]),
      .rem_re_o (rre[g+1]),
      .num_re_o (nre[g+1]),
      .rem_im_o (rim[g+1]),
      .num_im_o (nim[g+1])
    );
    logic             v_q;
    side_t            sb_q;
    logic [DEN_W-1:0] dq;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (adv) begin
        v_q <= vld[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sb_q <= sb[g];
        dq   <= den_c[g];
      end
    end
    assign vld[g+1]   = v_q;
    assign sb[g+1]    = sb_q;
    assign den_c[g+1] = dq;
  end

  // Final stage: pick magnitude per operation, round, saturate, register out.
  localparam logic [NUM_W-1:0] HALF  = NUM_W'(1) << (WORD_BITS - 1);
  localparam logic [NUM_W-1:0] FRAC1 = (NUM_W'(1) << FRAC_BITS) - NUM_W'(1);

  side_t            st;
  logic [NUM_W-1:0] qre, qim, fre, fim;
  logic             o_re, o_im;
  logic [WORD_BITS-1:0] w_re, w_im;

  assign st  = sb[NC];
  assign qre = nre[NC];
  assign qim = nim[NC];

  function automatic logic [NUM_W-1:0] floor_mag(input logic neg,
                                                 input logic [SW-1:0] m);
    logic [NUM_W-1:0] t;
    t = NUM_W'(m);
    if (neg) t = t + FRAC1;
    return t >> FRAC_BITS;
  endfunction

  function automatic logic [WORD_BITS:0] sat_w(input logic neg,
                                               input logic [NUM_W-1:0] m);
    logic [NUM_W-1:0] c;
    logic             ov;
    ov = 1'b0;
    c  = m;
    if (neg && m > HALF) begin
      ov = 1'b1;
      c  = HALF;
    end else if (!neg && m > HALF - NUM_W'(1)) begin
      ov = 1'b1;
      c  = HALF - NUM_W'(1);
    end
    if (neg) c = -c;
    return {ov, c[WORD_BITS-1:0]};
  endfunction

  always_comb begin
    case (st.op)
      OP_MUL: begin
        fre = floor_mag(st.nre, st.mre);
        fim = floor_mag(st.nim, st.mim);
      end
      OP_DIV: begin
        fre = qre;
        fim = qim;
      end
      default: begin
        fre = NUM_W'(st.mre);
        fim = NUM_W'(st.mim);
      end
    endcase
    {o_re, w_re} = sat_w(st.nre, fre);
    {o_im, w_im} = sat_w(st.nim, fim);
  end

  logic dz;
  assign dz = (st.op == OP_DIV) && st.dbz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= vld[NC];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_re_o         <= dz ? '0 : w_re;
      res_im_o         <= dz ? '0 : w_im;
      overflow_o       <= dz ? 1'b0 : (o_re | o_im);
      divide_by_zero_o <= dz;
    end
  end
endmodule

// ===== rtl/core/cau_div_cell.sv =====
// One restoring-division cell: produces one quotient bit for each of two lanes.
// Depends on nothing; chained by the top level.
module cau_div_cell #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [NUM_W-1:0] rem_re_i,
  input  logic [NUM_W-1:0] num_re_i,
  input  logic [NUM_W-1:0] rem_im_i,
  input  logic [NUM_W-1:0] num_im_i,
  output logic [NUM_W-1:0] rem_re_o,
  output logic [NUM_W-1:0] num_re_o,
  output logic [NUM_W-1:0] rem_im_o,
  output logic [NUM_W-1:0] num_im_o
);
  logic [NUM_W:0] tre, tim, dx;
  logic [NUM_W-1:0] rre_d, nre_d, rim_d, nim_d;

  always_comb begin
    dx    = {{(NUM_W+1-DEN_W){1'b0}}, den_i};
    tre   = {rem_re_i, num_re_i[NUM_W-1]};
    tim   = {rem_im_i, num_im_i[NUM_W-1]};
    nre_d = {num_re_i[NUM_W-2:0], 1'b0};
    nim_d = {num_im_i[NUM_W-2:0], 1'b0};
    if (tre >= dx) begin
      tre      = tre - dx;
      nre_d[0] = 1'b1;
    end
    if (tim >= dx) begin
      tim      = tim - dx;
      nim_d[0] = 1'b1;
    end
    rre_d = tre[NUM_W-1:0];
    rim_d = tim[NUM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rem_re_o <= rre_d;
      num_re_o <= nre_d;
      rem_im_o <= rim_d;
      num_im_o <= nim_d;
    end
  end
endmodule
